// ===== hw/rtl/mtet_pkg.sv =====
// ----------------------------------------------------------------------------
// mtet_pkg
// Shared types and codes for the timer event table.
// ----------------------------------------------------------------------------
package mtet_pkg;

	localparam int unsigned KIND_W = 3;
	localparam int unsigned SLOT_W = 3;
	localparam int unsigned TASK_W = 4;
	localparam int unsigned EV_W   = 16;
	localparam int unsigned TMO_W  = 32;
	localparam int unsigned EL_W   = 16;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ARM     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TICK    = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_NOT_FND = 2'd2;
	localparam logic [1:0] ST_BAD_IDX = 2'd3;

	localparam logic [1:0] ACT_ACK  = 2'd0;
	localparam logic [1:0] ACT_POST = 2'd1;
	localparam logic [1:0] ACT_FIRE = 2'd2;
	localparam logic [1:0] ACT_DONE = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [TASK_W-1:0] task_req;
		logic [EV_W-1:0]   event_bits;
		logic [TMO_W-1:0]  timeout;
		logic [EL_W-1:0]   elapsed;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [1:0]        action;
		logic [SLOT_W-1:0] slot_out;
		logic [TASK_W-1:0] task_out;
		logic [EV_W-1:0]   event_out;
		logic [31:0]       tick_count;
		logic              last;
	} out_item_t;

	// controller commands to the datapath
	typedef struct packed {
		logic load;     // capture the input beat, clear scan flags
		logic step;     // examine the entry at the scan index
		logic finish;   // apply the operation's result
		logic out_take; // the result register was drained
	} ctl_cmd_t;

	// datapath status back to the controller
	typedef struct packed {
		logic scan_end;  // scan index is at the last entry
		logic emit;      // the entry just examined gives a result
		logic out_full;  // result register holds a beat
		logic is_tick;   // captured beat is a tick
	} dp_stat_t;

endpackage

// ===== hw/rtl/mtet_datapath.sv =====
// ----------------------------------------------------------------------------
// mtet_datapath
// Timer table storage, one-entry-per-cycle scan (held while a result waits) and result register.
// ----------------------------------------------------------------------------
module mtet_datapath #(
	parameter int unsigned TIMER_COUNT = 8,
	parameter int unsigned TASK_COUNT  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtet_pkg::in_item_t  in_item,
	input  mtet_pkg::ctl_cmd_t  cmd,
	output mtet_pkg::dp_stat_t  stat,
	output mtet_pkg::out_item_t out_item
);

	localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	logic [mtet_pkg::TASK_W-1:0] task_q  [TIMER_COUNT];
	logic [mtet_pkg::EV_W-1:0]   ev_q    [TIMER_COUNT];
	logic [mtet_pkg::TMO_W-1:0]  rem_q   [TIMER_COUNT];
	logic [TIMER_COUNT-1:0]      run_q;
	logic [TIMER_COUNT-1:0]      cb_q;
	logic [31:0]                 ticks_q;

	mtet_pkg::in_item_t          op_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        free_hit_q, match_hit_q;
	logic [IDX_W-1:0]            free_idx_q, match_idx_q;
	mtet_pkg::out_item_t         res_q;
	logic                        full_q;

	logic                        ent_free, ent_match, ent_expire, ent_post, ent_fire;
	logic                        slot_ok, task_ok;
	logic [mtet_pkg::TMO_W-1:0]  el_ext;
	mtet_pkg::out_item_t         fin_res;

	assign el_ext    = {{(mtet_pkg::TMO_W-mtet_pkg::EL_W){1'b0}}, op_q.elapsed};
	assign slot_ok   = ({29'd0, op_q.slot} < 32'(TIMER_COUNT));
	assign task_ok   = ({28'd0, op_q.task_req} < 32'(TASK_COUNT));
	assign ent_free  = (ev_q[idx_q] == '0) && !cb_q[idx_q];
	assign ent_match = (task_q[idx_q] == op_q.task_req) && ((ev_q[idx_q] & op_q.event_bits) != '0)
		&& ((op_q.kind == mtet_pkg::KIND_CANCEL) || !cb_q[idx_q]);
	assign ent_expire = run_q[idx_q] && !(rem_q[idx_q] > el_ext);
	assign ent_post  = ent_expire && (ev_q[idx_q] != '0);
	assign ent_fire  = ent_expire && (ev_q[idx_q] == '0) && cb_q[idx_q];

	assign stat.scan_end = ({{(32-IDX_W){1'b0}}, idx_q} == 32'(TIMER_COUNT - 1));
	assign stat.emit     = cmd.step && (op_q.kind == mtet_pkg::KIND_TICK) && (ent_post || ent_fire);
	assign stat.out_full = full_q;
	assign stat.is_tick  = (op_q.kind == mtet_pkg::KIND_TICK);
	assign out_item      = res_q;

	// build the final beat of the operation
	always_comb begin
		fin_res            = '0;
		fin_res.last       = 1'b1;
		fin_res.tick_count = ticks_q;
		case (op_q.kind) inside
			mtet_pkg::KIND_ALLOC: begin
				if (free_hit_q) begin
					fin_res.slot_out = mtet_pkg::SLOT_W'(free_idx_q);
				end else begin
					fin_res.status = mtet_pkg::ST_NO_FREE;
				end
			end
			mtet_pkg::KIND_START, mtet_pkg::KIND_STOP, mtet_pkg::KIND_RELEASE: begin
				fin_res.slot_out = op_q.slot;
				if (!slot_ok) begin
					fin_res.status = mtet_pkg::ST_BAD_IDX;
				end
			end
			mtet_pkg::KIND_ARM: begin
				fin_res.task_out = op_q.task_req;
				if (!task_ok) begin
					fin_res.status = mtet_pkg::ST_BAD_IDX;
				end else if (match_hit_q) begin
					fin_res.slot_out = mtet_pkg::SLOT_W'(match_idx_q);
				end else if (free_hit_q) begin
					fin_res.slot_out = mtet_pkg::SLOT_W'(free_idx_q);
				end else begin
					fin_res.status = mtet_pkg::ST_NO_FREE;
				end
			end
			mtet_pkg::KIND_CANCEL: begin
				fin_res.task_out = op_q.task_req;
				if (!task_ok) begin
					fin_res.status = mtet_pkg::ST_BAD_IDX;
				end else if (match_hit_q) begin
					fin_res.slot_out = mtet_pkg::SLOT_W'(match_idx_q);
				end else begin
					fin_res.status = mtet_pkg::ST_NOT_FND;
				end
			end
			mtet_pkg::KIND_TICK: begin
				fin_res.action     = mtet_pkg::ACT_DONE;
				fin_res.tick_count = ticks_q + 32'd1;
			end
			default: begin
			end
		endcase
	end

	// table, scan and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				task_q[i] <= '0;
				ev_q[i]   <= '0;
				rem_q[i]  <= '0;
			end
			run_q       <= '0;
			cb_q        <= '0;
			ticks_q     <= '0;
			idx_q       <= '0;
			free_hit_q  <= 1'b0;
			match_hit_q <= 1'b0;
			free_idx_q  <= '0;
			match_idx_q <= '0;
			full_q      <= 1'b0;
			op_q        <= '0;
			res_q       <= '0;
		end else begin
			// hold the result until taken; refill on an expiry or a finish
			full_q <= (full_q && !cmd.out_take) || cmd.finish || stat.emit;
			if (cmd.load) begin
				op_q        <= in_item;
				idx_q       <= '0;
				free_hit_q  <= 1'b0;
				match_hit_q <= 1'b0;
			end
			// examine one entry
			if (cmd.step) begin
				if (!stat.scan_end) begin
					idx_q <= idx_q + 1'b1;
				end
				if (ent_free && !free_hit_q) begin
					free_hit_q <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (ent_match && !match_hit_q) begin
					match_hit_q <= 1'b1;
					match_idx_q <= idx_q;
				end
				if (op_q.kind == mtet_pkg::KIND_TICK && run_q[idx_q]) begin
					if (!ent_expire) begin
						rem_q[idx_q] <= rem_q[idx_q] - el_ext;
					end else if (ent_post) begin
						task_q[idx_q] <= '0;
						ev_q[idx_q]   <= '0;
						rem_q[idx_q]  <= '0;
						run_q[idx_q]  <= 1'b0;
						cb_q[idx_q]   <= 1'b0;
					end else begin
						rem_q[idx_q] <= '0;
						if (cb_q[idx_q]) begin
							run_q[idx_q] <= 1'b0;
						end
					end
				end
				if (stat.emit) begin
					res_q <= '{status: mtet_pkg::ST_OK,
						action: ent_post ? mtet_pkg::ACT_POST : mtet_pkg::ACT_FIRE,
						slot_out: mtet_pkg::SLOT_W'(idx_q),
						task_out: ent_post ? task_q[idx_q] : '0,
						event_out: ent_post ? ev_q[idx_q] : '0,
						tick_count: ticks_q, last: 1'b0};
				end
			end
			// apply the operation and post its final beat
			if (cmd.finish) begin
				res_q <= fin_res;
				case (op_q.kind) inside
					mtet_pkg::KIND_ALLOC: begin
						if (free_hit_q) begin
							task_q[free_idx_q] <= '0;
							ev_q[free_idx_q]   <= '0;
							cb_q[free_idx_q]   <= 1'b1;
							run_q[free_idx_q]  <= 1'b0;
						end
					end
					mtet_pkg::KIND_START, mtet_pkg::KIND_STOP, mtet_pkg::KIND_RELEASE: begin
						if (!slot_ok) begin
						end else if (op_q.kind == mtet_pkg::KIND_START) begin
							rem_q[IDX_W'(op_q.slot)] <= op_q.timeout;
							run_q[IDX_W'(op_q.slot)] <= 1'b1;
						end else if (op_q.kind == mtet_pkg::KIND_STOP) begin
							run_q[IDX_W'(op_q.slot)] <= 1'b0;
						end else begin
							task_q[IDX_W'(op_q.slot)] <= '0;
							ev_q[IDX_W'(op_q.slot)]   <= '0;
							rem_q[IDX_W'(op_q.slot)]  <= '0;
							run_q[IDX_W'(op_q.slot)]  <= 1'b0;
							cb_q[IDX_W'(op_q.slot)]   <= 1'b0;
						end
					end
					mtet_pkg::KIND_ARM: begin
						if (!task_ok) begin
						end else if (match_hit_q) begin
							rem_q[match_idx_q] <= op_q.timeout;
						end else if (free_hit_q) begin
							task_q[free_idx_q] <= op_q.task_req;
							ev_q[free_idx_q]   <= op_q.event_bits;
							rem_q[free_idx_q]  <= op_q.timeout;
							run_q[free_idx_q]  <= 1'b1;
						end
					end
					mtet_pkg::KIND_CANCEL: begin
						if (task_ok && match_hit_q) begin
							task_q[match_idx_q] <= '0;
							ev_q[match_idx_q]   <= '0;
							rem_q[match_idx_q]  <= '0;
							run_q[match_idx_q]  <= 1'b0;
							cb_q[match_idx_q]   <= 1'b0;
						end
					end
					mtet_pkg::KIND_TICK: begin
						ticks_q <= ticks_q + 32'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// a result is never overwritten while it waits
	assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !cmd.out_take |-> !cmd.finish && !stat.emit)
		else $error("result register overwritten");
	// the tick counter moves only when a tick finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		ticks_q != $past(ticks_q) |-> $past(cmd.finish) && $past(stat.is_tick))
		else $error("tick counter moved outside a tick");
	// a stopped entry never expires
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> run_q[idx_q])
		else $error("expiry on a stopped entry");

endmodule

// ===== hw/rtl/mtet_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtet_ctrl
// Sequencer: accept a beat, scan the table, finish and hand out results.
// ----------------------------------------------------------------------------
module mtet_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mtet_pkg::dp_stat_t stat,
	output mtet_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
	state_t state_q;
	logic   take;

	assign take      = stat.out_full && out_ready;
	assign out_valid = stat.out_full;
	assign in_ready  = (state_q == S_IDLE);

	// drive commands; stall the scan and the finish while a result waits
	always_comb begin
		cmd.out_take = take;
		cmd.load     = in_valid && in_ready;
		cmd.step     = (state_q == S_SCAN) && (!stat.out_full || take);
		cmd.finish   = (state_q == S_FINISH) && (!stat.out_full || take);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmd.step && stat.scan_end) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_SCAN)
		else $error("load did not start a scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && cmd.finish))
		else $error("step and finish together");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready)
		else $error("not idle after finish");

endmodule

// ===== hw/rtl/multi_timer_event_table.sv =====
// ----------------------------------------------------------------------------
// multi_timer_event_table
// Countdown timer table with callback and event timers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation (alloc, start, stop, release, arm,
//           cancel, tick). The block takes one operation at a time.
//   out_* : one or more result beats per operation; last marks the final one.
//   Each operation walks the table one entry per clock while no result
//   waits, then applies its result in a separate finish step.
//   A tick emits one beat per expired event or callback timer during the walk, then a done
//   beat carrying the new tick count.
//   When the receiver stalls, the walk pauses on the waiting result and
//   resumes after it is taken; nothing is dropped.
//   Reset clears every entry and the tick counter at once.
// ----------------------------------------------------------------------------
module multi_timer_event_table #(
	parameter int unsigned TIMER_COUNT = 8,
	parameter int unsigned TASK_COUNT  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtet_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mtet_pkg::out_item_t out_data
);

	mtet_pkg::ctl_cmd_t cmd;
	mtet_pkg::dp_stat_t stat;

	mtet_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	mtet_datapath #(.TIMER_COUNT(TIMER_COUNT), .TASK_COUNT(TASK_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_data), .cmd(cmd), .stat(stat), .out_item(out_data)
	);

endmodule
